// ===== hw/rtl/drrip_pkg.sv =====
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared types and constants of the DRRIP replacement engine with dead-block
// prediction: controller states, set roles, field widths and RRPV codes.
// ----------------------------------------------------------------------------
`default_nettype none

package drrip_pkg;

  // Fixed field widths of the transaction ports
  localparam int unsigned FUNC_W     = 1;
  localparam int unsigned SET_IN_W   = 11;
  localparam int unsigned WAY_IN_W   = 4;
  localparam int unsigned DRAW_W     = 5;
  localparam int unsigned VICTIM_W   = 4;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned COUNT_W    = 20;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b1;

  // Per-block 2-bit codes
  localparam logic [1:0] RRPV_HIT  = 2'd0;
  localparam logic [1:0] RRPV_NEAR = 2'd2;
  localparam logic [1:0] RRPV_FAR  = 2'd3;
  localparam logic [1:0] DEAD_ZERO = 2'd0;
  localparam logic [1:0] DEAD_SAT  = 2'd3;

  // Decay exponent limits and reset value
  localparam logic [CFG_W-1:0] DECAY_MIN   = 5'd1;
  localparam logic [CFG_W-1:0] DECAY_MAX   = 5'd20;
  localparam logic [CFG_W-1:0] DECAY_RESET = 5'd12;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_MODIFY
  } state_e;

  typedef enum logic [1:0] {
    ROLE_FOLLOWER,
    ROLE_SRRIP,
    ROLE_BRRIP
  } role_e;

endpackage

`default_nettype wire

// ===== hw/rtl/drrip_dead_block_replacement_top.sv =====
// ----------------------------------------------------------------------------
// drrip_dead_block_replacement_top
// Replacement engine of a SETS x WAYS cache: RRPV and dead counter per block,
// set-dueling selector, victim query and post-access update.
// ----------------------------------------------------------------------------
// Each set is one row in two single-port-read, single-port-write memories (RRPV
// row and dead-counter row, 2 bits per way, registered read). A transaction
// passes capture, row read, then modify and write back in the cycle the result
// is loaded, which waits until the result register is free; the next
// transaction is accepted the cycle after. An update that hits the decay period
// (every 2^decay_log2 updates) first walks every row of the dead-counter memory.
// After reset a clearing pass initializes every row of both memories; no
// transaction is accepted during it, configuration writes are. A finished
// result waits in the output register while a new transaction is accepted.
`default_nettype none

module drrip_dead_block_replacement_top #(
  parameter int unsigned SETS          = 2048,
  parameter int unsigned WAYS          = 16,
  parameter int unsigned LEADER_SETS   = 32,
  parameter int unsigned SELECTOR_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [drrip_pkg::CFG_W-1:0]       cfg_data_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [drrip_pkg::FUNC_W-1:0]      func_i,
  input  logic [drrip_pkg::SET_IN_W-1:0]    set_index_i,
  input  logic [drrip_pkg::WAY_IN_W-1:0]    way_i,
  input  logic                              hit_i,
  input  logic [drrip_pkg::DRAW_W-1:0]      rand_draw_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [drrip_pkg::VICTIM_W-1:0]    victim_way_o,
  output logic                              bypassed_o
);

  import drrip_pkg::*;

  localparam int unsigned SIDX_W      = $clog2(SETS);
  localparam int unsigned WIDX_W      = $clog2(WAYS);
  localparam int unsigned ROW_W       = 2 * WAYS;
  localparam int unsigned CNT_W       = $clog2(SETS + 1);
  localparam int unsigned RAW_STRIDE  = SETS / LEADER_SETS;
  localparam int unsigned STRIDE      = (RAW_STRIDE < 2) ? 2 : RAW_STRIDE;
  localparam int unsigned STRIDE_LOG  = $clog2(STRIDE);
  localparam int unsigned RECIP_SHIFT = SIDX_W + STRIDE_LOG;
  localparam int unsigned RECIP_W     = SIDX_W + 1;
  localparam int unsigned PROD_W      = SIDX_W + RECIP_W;
  localparam longint unsigned RECIP_M =
    ((64'd1 << RECIP_SHIFT) + 64'(STRIDE) - 64'd1) / 64'(STRIDE);
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX   = {SELECTOR_BITS{1'b1}};
  localparam logic [SELECTOR_BITS-1:0] SEL_RESET = {1'b0, {(SELECTOR_BITS-1){1'b1}}};

  // Remainder by a constant for quotients below 32: restoring compare-subtract.
  function automatic logic [31:0] mod_small(input logic [31:0] value,
                                            input logic [31:0] modulus);
    logic [31:0] rem;
    logic [36:0] step;
    rem = value;
    for (int k = 4; k >= 0; k--) begin
      step = 37'(modulus) << k;
      if (37'(rem) >= step) begin
        rem = rem - step[31:0];
      end
    end
    return rem;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SELECTOR_BITS-1:0] sel_q, sel_d;
  logic [COUNT_W-1:0]     count_q;
  logic [CFG_W-1:0]       decay_q;
  logic                   out_valid_q;
  logic [VICTIM_W-1:0]    victim_q;
  logic                   bypass_q;

  logic [FUNC_W-1:0]      func_q;
  logic [SIDX_W-1:0]      set_q;
  logic [WIDX_W-1:0]      way_q;
  logic                   hit_q;
  logic                   draw_zero_q;
  logic [SIDX_W-1:0]      quo_q;

  logic [ROW_W-1:0]       rrpv_mem [SETS];
  logic [ROW_W-1:0]       dead_mem [SETS];
  logic [ROW_W-1:0]       rrpv_rd_q;
  logic [ROW_W-1:0]       dead_rd_q;

  // --------------------------------------------------------------------------
  // Input reduction and decay period
  // --------------------------------------------------------------------------
  logic                   in_fire;
  logic                   out_free;
  logic [SIDX_W-1:0]      set_red;
  logic [WIDX_W-1:0]      way_red;
  logic [CFG_W-1:0]       decay_sh;
  logic [COUNT_W-1:0]     decay_mask;
  logic [COUNT_W-1:0]     count_inc;
  logic                   sweep_due;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign set_red = SIDX_W'(mod_small(32'(set_index_i), 32'(SETS)));
  assign way_red = WIDX_W'(mod_small(32'(way_i), 32'(WAYS)));

  always_comb begin
    if (decay_q < DECAY_MIN) begin
      decay_sh = DECAY_MIN;
    end else if (decay_q > DECAY_MAX) begin
      decay_sh = DECAY_MAX;
    end else begin
      decay_sh = decay_q;
    end
  end

  assign decay_mask = COUNT_W'(((COUNT_W+1)'(1) << decay_sh) - (COUNT_W+1)'(1));
  assign count_inc  = count_q + COUNT_W'(1);
  assign sweep_due  = (count_inc & decay_mask) == '0;

  // --------------------------------------------------------------------------
  // Leader set role: quotient by reciprocal in the read cycle, remainder after
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0]      quo_prod;
  logic [31:0]            stride_rem;
  logic                   leader_ok;
  role_e                  role;

  assign quo_prod = PROD_W'(set_q) * PROD_W'(RECIP_M);

  always_ff @(posedge clk_i) begin
    quo_q <= SIDX_W'(quo_prod >> RECIP_SHIFT);
  end

  assign stride_rem = 32'(set_q) - 32'(quo_q) * 32'(STRIDE);
  assign leader_ok  = 32'(quo_q) < 32'(LEADER_SETS);

  always_comb begin
    if (leader_ok && stride_rem == 32'd0) begin
      role = ROLE_SRRIP;
    end else if (leader_ok && stride_rem == 32'd1) begin
      role = ROLE_BRRIP;
    end else begin
      role = ROLE_FOLLOWER;
    end
  end

  // --------------------------------------------------------------------------
  // Row modify
  // --------------------------------------------------------------------------
  logic                   found_dead, found_far, found_near;
  logic [WIDX_W-1:0]      dead_idx, far_idx, near_idx, victim_idx;
  logic [ROW_W-1:0]       rrpv_aged;
  logic [ROW_W-1:0]       dead_decayed;
  logic [ROW_W-1:0]       rrpv_mod, dead_mod;
  logic [1:0]             way_dead;
  logic [1:0]             brrip_ins, ins_rrpv;
  logic                   upd_bypass;
  logic                   upd_insert;

  always_comb begin
    found_dead   = 1'b0;
    found_far    = 1'b0;
    found_near   = 1'b0;
    dead_idx     = '0;
    far_idx      = '0;
    near_idx     = '0;
    rrpv_aged    = rrpv_rd_q;
    dead_decayed = dead_rd_q;
    // descending scan leaves the lowest matching way
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (dead_rd_q[2*w +: 2] == DEAD_SAT) begin
        found_dead = 1'b1;
        dead_idx   = WIDX_W'(w);
      end
      if (rrpv_rd_q[2*w +: 2] == RRPV_FAR) begin
        found_far = 1'b1;
        far_idx   = WIDX_W'(w);
      end
      if (rrpv_rd_q[2*w +: 2] == RRPV_NEAR) begin
        found_near = 1'b1;
        near_idx   = WIDX_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (rrpv_rd_q[2*w +: 2] != RRPV_FAR) begin
        rrpv_aged[2*w +: 2] = rrpv_rd_q[2*w +: 2] + 2'd1;
      end
      if (dead_rd_q[2*w +: 2] != DEAD_ZERO) begin
        dead_decayed[2*w +: 2] = dead_rd_q[2*w +: 2] - 2'd1;
      end
    end
  end

  assign way_dead  = dead_rd_q[32'(way_q)*2 +: 2];
  assign brrip_ins = draw_zero_q ? RRPV_NEAR : RRPV_FAR;

  always_comb begin
    unique case (role)
      ROLE_SRRIP: ins_rrpv = RRPV_NEAR;
      ROLE_BRRIP: ins_rrpv = brrip_ins;
      default:    ins_rrpv = sel_q[SELECTOR_BITS-1] ? brrip_ins : RRPV_NEAR;
    endcase
  end

  always_comb begin
    rrpv_mod   = rrpv_rd_q;
    dead_mod   = dead_rd_q;
    victim_idx = '0;
    upd_bypass = 1'b0;
    upd_insert = 1'b0;
    if (func_q == FUNC_QUERY) begin
      priority if (found_dead) begin
        victim_idx = dead_idx;
      end else if (found_far) begin
        victim_idx = far_idx;
      end else begin
        // age the whole set; former near blocks are now far
        rrpv_mod = rrpv_aged;
        if (found_near) begin
          victim_idx = near_idx;
        end
      end
    end else begin
      priority if (hit_q) begin
        rrpv_mod[32'(way_q)*2 +: 2] = RRPV_HIT;
        dead_mod[32'(way_q)*2 +: 2] = DEAD_ZERO;
      end else if (way_dead == DEAD_SAT) begin
        rrpv_mod[32'(way_q)*2 +: 2] = RRPV_FAR;
        upd_bypass = 1'b1;
      end else begin
        rrpv_mod[32'(way_q)*2 +: 2] = ins_rrpv;
        dead_mod[32'(way_q)*2 +: 2] = way_dead + 2'd1;
        upd_insert = 1'b1;
      end
    end
  end

  always_comb begin
    sel_d = sel_q;
    if (state_q == ST_MODIFY && out_free && upd_insert) begin
      if (role == ROLE_SRRIP && sel_q != SEL_MAX) begin
        sel_d = sel_q + SELECTOR_BITS'(1);
      end else if (role == ROLE_BRRIP && sel_q != '0) begin
        sel_d = sel_q - SELECTOR_BITS'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Controller: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CNT_W'(SETS - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire) begin
          if (func_i == FUNC_UPDATE && sweep_due) begin
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_SWEEP: begin
        if (cnt_q == CNT_W'(SETS)) begin
          state_d = ST_READ;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_READ: begin
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        cnt_d   = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller: outputs and memory control
  // --------------------------------------------------------------------------
  logic                   mem_rd_en;
  logic [SIDX_W-1:0]      mem_rd_addr;
  logic                   rrpv_we, dead_we;
  logic [SIDX_W-1:0]      mem_wr_addr;
  logic [ROW_W-1:0]       rrpv_wr_row, dead_wr_row;

  always_comb begin
    in_ready_o  = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = set_q;
    rrpv_we     = 1'b0;
    dead_we     = 1'b0;
    mem_wr_addr = set_q;
    rrpv_wr_row = rrpv_mod;
    dead_wr_row = dead_mod;
    unique case (state_q)
      ST_CLEAR: begin
        rrpv_we     = 1'b1;
        dead_we     = 1'b1;
        mem_wr_addr = cnt_q[SIDX_W-1:0];
        rrpv_wr_row = {WAYS{RRPV_FAR}};
        dead_wr_row = {WAYS{DEAD_ZERO}};
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_SWEEP: begin
        // read row cnt, write back decremented row cnt-1
        mem_rd_en   = cnt_q < CNT_W'(SETS);
        mem_rd_addr = cnt_q[SIDX_W-1:0];
        dead_we     = cnt_q != '0;
        mem_wr_addr = SIDX_W'(cnt_q - CNT_W'(1));
        dead_wr_row = dead_decayed;
      end
      ST_READ: begin
        mem_rd_en = 1'b1;
      end
      ST_MODIFY: begin
        rrpv_we = out_free;
        dead_we = out_free;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Row memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rrpv_we) begin
      rrpv_mem[mem_wr_addr] <= rrpv_wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dead_we) begin
      dead_mem[mem_wr_addr] <= dead_wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_rd_en) begin
      rrpv_rd_q <= rrpv_mem[mem_rd_addr];
      dead_rd_q <= dead_mem[mem_rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      sel_q       <= SEL_RESET;
      count_q     <= '0;
      decay_q     <= DECAY_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      if (in_fire && func_i == FUNC_UPDATE) begin
        count_q <= count_inc;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        decay_q <= cfg_data_i;
      end
      if (state_q == ST_MODIFY && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q      <= func_i;
      set_q       <= set_red;
      way_q       <= way_red;
      hit_q       <= hit_i;
      draw_zero_q <= rand_draw_i == '0;
    end
    if (state_q == ST_MODIFY && out_free) begin
      victim_q <= (func_q == FUNC_QUERY) ? VICTIM_W'(victim_idx) : '0;
      bypass_q <= (func_q == FUNC_UPDATE) && upd_bypass;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign victim_way_o = victim_q;
  assign bypassed_o   = bypass_q;

endmodule

`default_nettype wire
